// File: hw/rtl/tile_map_pixel_renderer_unit_assert.svh
// ----------------------------------------------------------------------------
// tile map pixel renderer assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_PIXEL_RENDERER_UNIT_ASSERT_SVH
`define TILE_MAP_PIXEL_RENDERER_UNIT_ASSERT_SVH

// same-cycle implication
`define TMPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmpr assertion failed");

// next-cycle implication
`define TMPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmpr assertion failed");

// at most one bit set
`define TMPR_ASSERT_ONEHOT0(label, clk, rst, vec) \
  label: assert property (@(posedge clk) disable iff (rst) $onehot0(vec)) \
    else $error("tmpr assertion failed");

`endif

// File: hw/rtl/tmpr_pkg.sv
// ----------------------------------------------------------------------------
// tmpr_pkg
// shared constants and controller/datapath interface types for the renderer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmpr_pkg;

  // action codes carried in the input tuser
  localparam logic [1:0] ACT_LOAD_TILE = 2'd0;
  localparam logic [1:0] ACT_LOAD_PAL  = 2'd1;
  localparam logic [1:0] ACT_DRAW      = 2'd2;

  // storage sizes
  localparam int TILE_STORE_BYTES_DEF = 65536;
  localparam int PALETTE_ENTRIES      = 256;
  localparam int PAL_AW               = $clog2(PALETTE_ENTRIES);

  // field widths
  localparam int ACTION_W   = 2;
  localparam int ADDRESS_W  = 16;
  localparam int DATA_W     = 32;
  localparam int ENTRY_W    = 16;
  localparam int POS_W      = 8;
  localparam int TILE_W     = 10;
  localparam int PIXEL_W    = 11;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  // one tile row: eight 4-bit pixels in a 32-bit word
  localparam int ROW_W   = 32;
  localparam int ROWS    = 8;
  localparam int PIXELS  = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic load_tile;
    logic load_pal;
    logic start;
    logic fetch;
    logic scan;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic fetch_done;
    logic scan_done;
  } dp_status_t;

endpackage

// File: hw/rtl/tmpr_ctrl.sv
// ----------------------------------------------------------------------------
// tmpr_ctrl
// state machine: store clearing pass, load/draw dispatch, row fetch and scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmpr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [9:0]                in_tile,
  output tmpr_pkg::dp_cmd_t         cmd,
  input  tmpr_pkg::dp_status_t      status
);
  import tmpr_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_LOAD_TILE: cmd.load_tile = 1'b1;
            ACT_LOAD_PAL:  cmd.load_pal = 1'b1;
            ACT_DRAW: begin
              if (in_tile != '0) begin
                cmd.start  = 1'b1;
                state_next = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        if (status.fetch_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/tmpr_datapath.sv
// ----------------------------------------------------------------------------
// tmpr_datapath
// tile row memory, palette memory, row buffer with pixel scan, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tile_map_pixel_renderer_unit_assert.svh"

module tmpr_datapath #(
  parameter int TILE_STORE_BYTES = tmpr_pkg::TILE_STORE_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tmpr_pkg::dp_cmd_t                    cmd,
  output tmpr_pkg::dp_status_t                 status,
  input  logic [tmpr_pkg::ADDRESS_W-1:0]       address,
  input  logic [tmpr_pkg::DATA_W-1:0]          load_data,
  input  logic [tmpr_pkg::ENTRY_W-1:0]         map_entry,
  input  logic [tmpr_pkg::POS_W-1:0]           tile_col,
  input  logic [tmpr_pkg::POS_W-1:0]           tile_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tmpr_pkg::OUT_TDATA_W-1:0]     out_data,
  output logic                                 out_last
);
  import tmpr_pkg::*;

  localparam int WORDS   = TILE_STORE_BYTES / 4;
  localparam int WORD_AW = $clog2(WORDS);
  localparam logic [ADDRESS_W:0] STORE_LIMIT = (ADDRESS_W + 1)'(TILE_STORE_BYTES);
  localparam logic [ADDRESS_W:0] PAL_LIMIT   = (ADDRESS_W + 1)'(PALETTE_ENTRIES);

  // tile store, one 32-bit row word per address
  logic [ROW_W-1:0]   tile_mem [WORDS];
  logic [ROW_W-1:0]   tile_q;
  logic [WORD_AW-1:0] clr_addr;
  logic [WORD_AW-1:0] tile_raddr;
  logic               tile_we;
  logic               tile_re;

  // palette store
  logic [DATA_W-1:0]  pal_mem [PALETTE_ENTRIES];
  logic [DATA_W-1:0]  argb_q;
  logic               pal_we;

  // draw context
  logic [TILE_W-1:0]  tile_num;
  logic               hflip;
  logic               vflip;
  logic [3:0]         bank;
  logic [POS_W-1:0]   col_q;
  logic [POS_W-1:0]   row_q;

  // fetch and scan
  logic [3:0]                fcnt;
  logic [ROWS*ROW_W-1:0]     row_buf;
  logic [PIXELS-1:0]         mask;
  logic [ROWS-1:0]           row_nz;
  logic [5:0]                pos;
  logic                      slot_free;
  logic                      step;
  logic                      issue;
  logic                      rest_empty;
  logic [2:0]                dx;
  logic [2:0]                dy;

  // output pixel registers
  logic [PIXEL_W-1:0]  px_q;
  logic [PIXEL_W-1:0]  py_q;
  logic                last_q;

  assign tile_we    = cmd.load_tile && ({1'b0, address} < STORE_LIMIT);
  assign pal_we     = cmd.load_pal && ({1'b0, address} < PAL_LIMIT);
  assign tile_re    = cmd.fetch && !fcnt[3];
  assign tile_raddr = WORD_AW'({tile_num, fcnt[2:0]});

  // tile memory: clear pass or byte load, row read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tile_mem[clr_addr] <= '0;
    end else if (tile_we) begin
      tile_mem[address[WORD_AW+1:2]][{address[1:0], 3'b000} +: 8] <= load_data[7:0];
    end
    if (tile_re) begin
      tile_q <= tile_mem[tile_raddr];
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // scan step: transparent pixels skip, visible ones wait for the output slot
  assign slot_free  = !out_valid || out_ready;
  assign step       = cmd.scan && (!mask[0] || slot_free);
  assign issue      = cmd.scan && mask[0] && slot_free;
  assign rest_empty = (mask[PIXELS-1:1] == '0);

  assign status.clear_done = cmd.clear && (clr_addr == WORD_AW'(WORDS - 1));
  assign status.fetch_done = cmd.fetch && (fcnt == 4'd8);
  assign status.scan_done  = step && rest_empty;

  // palette memory: load write, read per visible pixel
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[address[PAL_AW-1:0]] <= load_data;
    end
    if (issue) begin
      argb_q <= pal_mem[{bank, row_buf[3:0]}];
    end
  end

  // latch the map entry at draw start
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tile_num <= map_entry[TILE_W-1:0];
      hflip    <= map_entry[10];
      vflip    <= map_entry[11];
      bank     <= map_entry[15:12];
      col_q    <= tile_col;
      row_q    <= tile_row;
    end
  end

  // fetch counter: reads rows 0..7, captures each row in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0;
    end else if (cmd.start) begin
      fcnt <= '0;
    end else if (cmd.fetch && !status.fetch_done) begin
      fcnt <= fcnt + 1'b1;
    end
  end

  // visible-pixel flags of the returned row word
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      row_nz[i] = (tile_q[4*i +: 4] != 4'd0);
    end
  end

  // row buffer and visibility mask: fill on capture, shift on scan step
  always_ff @(posedge clk) begin
    if (cmd.fetch && (fcnt != 4'd0)) begin
      row_buf <= {tile_q, row_buf[ROWS*ROW_W-1:ROW_W]};
      mask    <= {row_nz, mask[PIXELS-1:ROWS]};
    end else if (step) begin
      row_buf <= row_buf >> 4;
      mask    <= mask >> 1;
    end
  end

  // source pixel position within the tile
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.start) begin
      pos <= '0;
    end else if (step) begin
      pos <= pos + 1'b1;
    end
  end

  assign dx = hflip ? ~pos[2:0] : pos[2:0];
  assign dy = vflip ? ~pos[5:3] : pos[5:3];

  // output pixel register
  always_ff @(posedge clk) begin
    if (issue) begin
      px_q   <= {col_q, dx};
      py_q   <= {row_q, dy};
      last_q <= rest_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {2'b00, argb_q, py_q, px_q};
  assign out_last = last_q;

  // checks
  `TMPR_ASSERT_ONEHOT0(a_cmd_onehot, clk, rst, cmd)
  `TMPR_ASSERT_NOW(a_scan_after_fetch, clk, rst, cmd.scan, fcnt == 4'd8)
  `TMPR_ASSERT_NEXT(a_mask_empty_at_end, clk, rst, status.scan_done, mask == '0)

endmodule

// File: hw/rtl/tile_map_pixel_renderer_unit.sv
// ----------------------------------------------------------------------------
// tile_map_pixel_renderer_unit
// 4-bit-per-pixel tile background renderer with tile byte and ARGB palette stores
// ----------------------------------------------------------------------------
// After reset the tile store is cleared one 4-byte row word per cycle, with
// no item taken during that pass. Tile and palette loads are written from the
// idle state, which takes the next item right after them. A draw of a nonzero
// tile is accepted in the idle state, reads the eight row words of the tile
// from the tile memory, and then scans one pixel position per cycle up to the
// last visible pixel, holding on a visible pixel while the output side stalls;
// no item is taken until that scan ends. Tile zero and fully transparent tiles
// produce no transfer. Visible pixels leave at most one per cycle through a
// registered output, in source order, with tlast on the last.
`timescale 1ns / 1ps

module tile_map_pixel_renderer_unit #(
  parameter int TILE_STORE_BYTES = tmpr_pkg::TILE_STORE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // address[15:0], load_data[47:16], map_entry[63:48], tile_col[71:64],
  // tile_row[79:72]
  input  logic [tmpr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action[1:0]
  input  logic [tmpr_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x[10:0], pixel_y[21:11], argb[53:22], zero fill[55:54]
  output logic [tmpr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // last_pixel
  output logic                                m_axis_tlast
);
  import tmpr_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [ADDRESS_W-1:0] address;
  logic [DATA_W-1:0]    load_data;
  logic [ENTRY_W-1:0]   map_entry;
  logic [POS_W-1:0]     tile_col;
  logic [POS_W-1:0]     tile_row;

  // unpack input fields
  assign address   = s_axis_tdata[15:0];
  assign load_data = s_axis_tdata[47:16];
  assign map_entry = s_axis_tdata[63:48];
  assign tile_col  = s_axis_tdata[71:64];
  assign tile_row  = s_axis_tdata[79:72];

  tmpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_tile   (map_entry[TILE_W-1:0]),
    .cmd       (cmd),
    .status    (status)
  );

  tmpr_datapath #(
    .TILE_STORE_BYTES (TILE_STORE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .address   (address),
    .load_data (load_data),
    .map_entry (map_entry),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tile map pixel renderer: tile byte and palette
// loads fill shadow stores, each draw is rendered from them into the expected
// pixel writes, and every pixel transfer is compared field by field
// ----------------------------------------------------------------------------

module tb;
  import tmpr_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int TILE_BYTES = TILE_STORE_BYTES_DEF;
  localparam int TAIL_CYCLES = 100;
  localparam int ITEM_TARGET = 180;
  localparam int unsigned CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [ADDRESS_W-1:0] address;
    logic [DATA_W-1:0]    load_data;
    logic [ENTRY_W-1:0]   map_entry;
    logic [POS_W-1:0]     tile_col;
    logic [POS_W-1:0]     tile_row;
  } render_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] px_x;
    logic [PIXEL_W-1:0] px_y;
    logic [DATA_W-1:0]  argb;
    logic               last_pixel;
  } pixel_write_t;

  // shadow stores plus the queue of pixel writes still owed by the block
  class pixel_scoreboard;
    logic [7:0]   tile_mem [TILE_BYTES];
    logic [31:0]  pal_mem [PALETTE_ENTRIES];
    bit           pal_known [PALETTE_ENTRIES];
    pixel_write_t pixel_q [$];
    int           errors;
    int           pixels_seen;
    int           draws;

    function new();
      foreach (tile_mem[i]) tile_mem[i] = 8'h00;
      foreach (pal_known[i]) begin
        pal_known[i] = 1'b0;
        pal_mem[i] = '0;
      end
      errors = 0;
      pixels_seen = 0;
      draws = 0;
    endfunction

    // color index of source pixel (x, y), low nibble first within a byte
    function logic [3:0] color_at(logic [TILE_W-1:0] tile_num, int x, int y);
      int addr;
      logic [7:0] b;
      addr = int'(tile_num) * 32 + y * 4 + x / 2;
      b = (addr < TILE_BYTES) ? tile_mem[addr] : 8'h00;
      return (x % 2 == 1) ? b[7:4] : b[3:0];
    endfunction

    // update the stores or queue the pixel writes of one accepted transfer
    function void note_item(render_item_t it);
      logic [TILE_W-1:0] tile_num;
      logic [3:0]        bank;
      logic [3:0]        ci;
      logic [2:0]        dx;
      logic [2:0]        dy;
      pixel_write_t      held;
      bit                have_held;
      have_held = 1'b0;
      case (it.action)
        ACT_LOAD_TILE: begin
          if (int'(it.address) < TILE_BYTES) tile_mem[it.address] = it.load_data[7:0];
        end
        ACT_LOAD_PAL: begin
          if (int'(it.address) < PALETTE_ENTRIES) begin
            pal_mem[it.address[PAL_AW-1:0]] = it.load_data;
            pal_known[it.address[PAL_AW-1:0]] = 1'b1;
          end
        end
        ACT_DRAW: begin
          draws++;
          tile_num = it.map_entry[TILE_W-1:0];
          bank = it.map_entry[15:12];
          if (tile_num != '0) begin
            for (int y = 0; y < ROWS; y++) begin
              for (int x = 0; x < 8; x++) begin
                ci = color_at(tile_num, x, y);
                if (ci != 4'd0) begin
                  // hold one back so the final write can carry the marker
                  if (have_held) pixel_q.push_back(held);
                  dx = it.map_entry[10] ? 3'(7 - x) : 3'(x);
                  dy = it.map_entry[11] ? 3'(7 - y) : 3'(y);
                  held.px_x = {it.tile_col, dx};
                  held.px_y = {it.tile_row, dy};
                  held.argb = pal_mem[{bank, ci}];
                  held.last_pixel = 1'b0;
                  have_held = 1'b1;
                end
              end
            end
          end
          if (have_held) begin
            held.last_pixel = 1'b1;
            pixel_q.push_back(held);
          end
        end
        default: ;  // reserved action code is dropped
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_pixel(pixel_write_t got);
      pixel_write_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel transfer with nothing pending: x=%0d y=%0d argb=%h",
                         got.px_x, got.px_y, got.argb));
        return;
      end
      want = pixel_q.pop_front();
      pixels_seen++;
      if (got.px_x !== want.px_x)
        report($sformatf("pixel_x got %0d want %0d", got.px_x, want.px_x));
      if (got.px_y !== want.px_y)
        report($sformatf("pixel_y got %0d want %0d", got.px_y, want.px_y));
      if (got.argb !== want.argb)
        report($sformatf("argb got %h want %h at x=%0d y=%0d",
                         got.argb, want.argb, want.px_x, want.px_y));
      if (got.last_pixel !== want.last_pixel)
        report($sformatf("tlast got %0b want %0b at x=%0d y=%0d",
                         got.last_pixel, want.last_pixel, want.px_x, want.px_y));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  pixel_scoreboard sb;
  int              items_in = 0;
  int              src_idle_pct = 0;
  int              sink_stall_pct = 0;
  int unsigned     cycle_count = 0;

  tile_map_pixel_renderer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // reset held from the start, then released once
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // output side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // pixel transfer monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_pixel({m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tdata[53:22],
                      m_axis_tlast});
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic push_item(logic [1:0] action, logic [15:0] address, logic [31:0] load_data,
                           logic [15:0] map_entry, logic [7:0] col, logic [7:0] row);
    render_item_t it;
    it = '{action: action, address: address, load_data: load_data, map_entry: map_entry,
           tile_col: col, tile_row: row};
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {it.tile_row, it.tile_col, it.map_entry, it.load_data, it.address};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(it);
    items_in++;
  endtask

  task automatic load_tile(logic [15:0] address, logic [31:0] load_data);
    push_item(ACT_LOAD_TILE, address, load_data, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic load_pal(logic [15:0] index, logic [31:0] color);
    push_item(ACT_LOAD_PAL, index, color, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // draw an entry, first loading any palette color it needs that was never set
  task automatic draw_entry(logic [15:0] entry, logic [7:0] col, logic [7:0] row);
    logic [3:0] ci;
    logic [7:0] idx;
    if (entry[TILE_W-1:0] != '0) begin
      for (int y = 0; y < ROWS; y++) begin
        for (int x = 0; x < 8; x++) begin
          ci = sb.color_at(entry[TILE_W-1:0], x, y);
          idx = {entry[15:12], ci};
          if (ci != 4'd0 && !sb.pal_known[idx]) load_pal(16'(idx), $urandom);
        end
      end
    end
    push_item(ACT_DRAW, 16'($urandom), $urandom, entry, col, row);
  endtask

  // sender holds off until every pending pixel has left, then lets the block settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TILE_W-1:0] pool_tile();
    case ($urandom_range(5))
      0: return 10'd1;
      1: return 10'd2;
      2: return 10'd3;
      3: return 10'd511;
      4: return 10'd512;
      default: return 10'd1023;
    endcase
  endfunction

  // one random step: rewrite part of a tile, draw an entry, or noise
  task automatic random_round();
    int                pick;
    logic [TILE_W-1:0] t;
    logic [7:0]        b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      t = pool_tile();
      repeat ($urandom_range(1, 10)) begin
        b = 8'($urandom);
        case ($urandom_range(3))
          0: b[3:0] = 4'd0;
          1: b[7:4] = 4'd0;
          default: ;
        endcase
        load_tile(16'(int'(t) * 32 + $urandom_range(31)), {24'($urandom), b});
      end
    end else if (pick < 85) begin
      case ($urandom_range(9))
        0: t = '0;
        1: t = 10'($urandom_range(1, 1023));
        default: t = pool_tile();
      endcase
      draw_entry({4'($urandom), 2'($urandom), t}, 8'($urandom), 8'($urandom));
    end else begin
      case ($urandom_range(3))
        0: push_item(ACT_RESERVED, 16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                     8'($urandom));
        1: load_pal(16'($urandom_range(PALETTE_ENTRIES, 65535)), $urandom);
        2: load_tile(16'($urandom), $urandom);
        default: load_pal(16'($urandom_range(PALETTE_ENTRIES - 1)), $urandom);
      endcase
    end
  endtask

  initial begin
    int phase_len;
    int start_items;
    sb = new();

    // tile 1 uses colors 1 and 15 in its first and last rows
    load_tile(16'd32, 32'h000000F1);
    load_tile(16'd35, 32'hFFFFFF0F);
    load_tile(16'd63, 32'hABCDEF10);
    // tile 1023 sits at the top of the drawable area
    load_tile(16'd32736, 32'h00000001);
    load_tile(16'd32767, 32'h000000F0);
    // bytes that no draw can read
    load_tile(16'd0, 32'hFFFFFFFF);
    load_tile(16'hFFFF, 32'h5A5A5AA5);
    // palette indexes past the end are dropped
    load_pal(16'd256, 32'h12345678);
    load_pal(16'hFFFF, 32'hFFFFFFFF);
    load_pal(16'd0, 32'h00000000);
    load_pal(16'd1, $urandom);
    load_pal(16'd15, $urandom);
    load_pal(16'd241, 32'h00000000);
    load_pal(16'd255, 32'hFFFFFFFF);
    // tile zero with every other bit set draws nothing
    draw_entry(16'hFC00, 8'hFF, 8'hFF);
    draw_entry(16'h0001, 8'h00, 8'h00);
    // both flips, bank 15, far corner of the map
    draw_entry(16'hFC01, 8'hFF, 8'hFF);
    draw_entry(16'h0401, 8'h12, 8'h34);
    draw_entry(16'hF801, 8'h55, 8'hAA);
    draw_entry(16'hF3FF, 8'h80, 8'h01);
    // never written tile is fully transparent
    draw_entry(16'h0005, 8'h07, 8'h70);
    push_item(ACT_RESERVED, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    drain();

    // pacing phases: none, sender gaps, receiver stalls, both
    start_items = items_in;
    phase_len = (ITEM_TARGET - start_items) / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 11; sink_stall_pct = 11; end
      endcase
      while (items_in < start_items + (ph + 1) * phase_len) random_round();
      drain();
    end

    $display("run covered %0d input transfers, %0d map entry draws, %0d pixel writes checked",
             items_in, sb.draws, sb.pixels_seen);
    $display("flips, palette banks, tile zero, transparent tiles and dropped loads included, "
             , "%0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: tile_map_pixel_renderer_unit.f
+incdir+hw/rtl
hw/rtl/tmpr_pkg.sv
hw/rtl/tmpr_ctrl.sv
hw/rtl/tmpr_datapath.sv
hw/rtl/tile_map_pixel_renderer_unit.sv
verif/tb.sv
